// ===== hdl/epts_pkg.sv =====
// ----------------------------------------------------------------------------
// epts_pkg: shared codes for the effective priority task scheduler
// Item modes, result status codes, slot states, config register indexes and
// default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package epts_pkg;

    localparam int SLOTS_DEF         = 16;
    localparam int EFF_PRIO_BITS_DEF = 10;
    localparam int SLEEP_W           = 24;

    localparam logic [7:0] LOWEST_RST  = 8'd1;
    localparam logic [7:0] HIGHEST_RST = 8'd255;
    localparam logic [7:0] TICKS_RST   = 8'd100;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_CREATE = 3'd1,
        MODE_TERM   = 3'd2,
        MODE_SLEEP  = 3'd3,
        MODE_SETP   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SLOT  = 2'd1,
        STAT_BAD_PRIO = 2'd2,
        STAT_NO_CUR   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_FREE  = 3'd0,
        ST_READY = 3'd1,
        ST_RUN   = 3'd2,
        ST_SLEEP = 3'd3,
        ST_DEAD  = 3'd4
    } slot_st_t;

    typedef enum logic [1:0] {
        CFG_LOWEST  = 2'd0,
        CFG_HIGHEST = 2'd1,
        CFG_TICKS   = 2'd2
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== hdl/effective_priority_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// effective_priority_task_scheduler_core: slot table task scheduler
// Keeps per-slot records and the ready order in two synchronous memories and
// applies one kernel event per item by read-modify-write sweeps.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir | handshake
//  --------+------------------------------------------+-----+-----------------
//  in      | mode, sleep_units, new_priority          | in  | in_valid/in_ready
//  out     | status, created_slot, running_slot,      | out | out_valid/out_ready
//          | idle, switched, recalculated             |     |
//  cfg     | cfg_index, cfg_data                      | in  | cfg_write
//
//  One item at a time. A tick sweeps every slot for sleepers, then runs a
//  selection over the ready order when it must reschedule or none runs; a
//  selection that recalculates adds a sweep over every slot and a second
//  selection. A set-priority item runs the bit-serial divider unless the
//  task's base is zero. After reset all slots read as free (fill count), no
//  clearing pass. A stalled result is held in the output register while the
//  next item is already taken.
// ----------------------------------------------------------------------------
`default_nettype none

module effective_priority_task_scheduler_core #(
    parameter int SLOTS         = epts_pkg::SLOTS_DEF,
    parameter int EFF_PRIO_BITS = epts_pkg::EFF_PRIO_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [15:0] sleep_units,
    input  wire logic [7:0]  new_priority,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [3:0]       created_slot,
    output logic [3:0]       running_slot,
    output logic             idle,
    output logic             switched,
    output logic             recalculated
);

    localparam int SW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int EW  = (EFF_PRIO_BITS > 8) ? EFF_PRIO_BITS : 8;
    localparam int NW  = EW + 9;
    localparam int DCW = $clog2(NW + 1);
    localparam int SLW = epts_pkg::SLEEP_W;
    localparam logic [EW-1:0] EFF_MAX = EW'((1 << EFF_PRIO_BITS) - 1);

    typedef struct packed {
        epts_pkg::slot_st_t st;
        logic [7:0]         base;
        logic [EW-1:0]      eff;
        logic [SLW-1:0]     sleep;
    } rec_t;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_CUR      = 14'b00000000000010,
        S_WAKE     = 14'b00000000000100,
        S_CHILD    = 14'b00000000001000,
        S_REMOVE   = 14'b00000000010000,
        S_DIV      = 14'b00000000100000,
        S_PRIO_WR  = 14'b00000001000000,
        S_SEL      = 14'b00000010000000,
        S_PICK     = 14'b00000100000000,
        S_PICK_END = 14'b00001000000000,
        S_RECALC   = 14'b00010000000000,
        S_DEMOTE   = 14'b00100000000000,
        S_PROMOTE  = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    // memories
    rec_t          slot_mem [SLOTS];
    rec_t          slot_q;
    logic [SW-1:0] sq_idx_reg;
    logic          s_re, s_we;
    logic [SW-1:0] s_raddr, s_waddr;
    rec_t          s_wdata;

    logic [SW-1:0] rdy_mem [SLOTS];
    logic [SW-1:0] rdy_q;
    logic [SW-1:0] rq_idx_reg;
    logic          r_re, r_we;
    logic [SW-1:0] r_raddr, r_waddr, r_wdata;

    // control
    state_t          state_reg, state_next;
    logic            has_cur_reg, has_cur_next;
    logic [SW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   rc_reg, rc_next;
    logic [CW-1:0]   alloc_reg, alloc_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      low_reg, low_next;
    logic [7:0]      high_reg, high_next;
    logic [7:0]      tpu_reg, tpu_next;
    logic [CW-1:0]   sk_reg, sk_next;
    logic            v1_reg, v1_next;
    logic            v2_reg, v2_next;
    logic            resched_reg, resched_next;
    logic            recalc_reg, recalc_next;
    logic            found_reg, found_next;
    logic            best_valid_reg, best_valid_next;
    logic            lowered_reg, lowered_next;
    logic [DCW-1:0]  cnt_reg, cnt_next;

    // payload
    logic [2:0]        mode_reg, mode_next;
    logic [15:0]       units_reg, units_next;
    logic [7:0]        newp_reg, newp_next;
    logic              prev_has_reg, prev_has_next;
    logic [SW-1:0]     prev_cur_reg, prev_cur_next;
    epts_pkg::status_t stat_reg, stat_next;
    logic [SW-1:0]     created_reg, created_next;
    logic [EW-1:0]     cur_eff_reg, cur_eff_next;
    logic [7:0]        ch_base_reg, ch_base_next;
    logic [EW-1:0]     ch_eff_reg, ch_eff_next;
    logic [SW-1:0]     best_reg, best_next;
    rec_t              best_rec_reg, best_rec_next;
    rec_t              rec_reg, rec_next;
    logic [NW-1:0]     num_reg, num_next;
    logic [8:0]        rem_reg, rem_next;
    logic [8:0]        dvs_reg, dvs_next;
    logic [1:0]        o_status_reg, o_status_next;
    logic [3:0]        o_created_reg, o_created_next;
    logic [3:0]        o_running_reg, o_running_next;
    logic              o_idle_reg, o_idle_next;
    logic              o_switched_reg, o_switched_next;
    logic              o_recalc_reg, o_recalc_next;

    // datapath helpers
    logic               accept_in;
    logic               sq_live;
    epts_pkg::slot_st_t sq_st;
    logic [EW-1:0]      eff_dec;
    logic [SLW-1:0]     sleep_prod;
    logic [NW-1:0]      recalc_sum;
    logic [EW-1:0]      recalc_eff;
    logic               set_lower;
    logic [8:0]         mult_m;
    logic [NW-1:0]      set_prod;
    logic [9:0]         rem_sh;
    logic               div_take;
    logic [EW-1:0]      q_sat;
    logic [SW+3:0]      cur_ext, created_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept_in = in_valid && in_ready;

    assign sq_live    = (CW'(sq_idx_reg) < alloc_reg);
    assign sq_st      = sq_live ? slot_q.st : epts_pkg::ST_FREE;
    assign eff_dec    = (slot_q.eff != '0) ? slot_q.eff - EW'(1) : '0;
    assign sleep_prod = units_reg * tpu_reg;
    assign recalc_sum = NW'(slot_q.eff >> 1) + NW'(slot_q.base);
    assign recalc_eff = (recalc_sum > NW'(EFF_MAX)) ? EFF_MAX : recalc_sum[EW-1:0];

    assign set_lower  = (newp_reg < slot_q.base);
    assign mult_m     = set_lower ? {1'b0, newp_reg}
                                  : ({1'b0, newp_reg} + {1'b0, slot_q.base});
    assign set_prod   = NW'(slot_q.eff) * NW'(mult_m);

    assign rem_sh     = {rem_reg, num_reg[NW-1]};
    assign div_take   = (rem_sh >= {1'b0, dvs_reg});
    assign q_sat      = (num_reg > NW'(EFF_MAX)) ? EFF_MAX : num_reg[EW-1:0];

    assign cur_ext     = {4'b0000, cur_reg};
    assign created_ext = {4'b0000, created_reg};

    // record memory, same-cycle write forwarded to the read port
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            slot_mem[s_waddr] <= s_wdata;
        end
        if (s_re)
        begin
            slot_q     <= (s_we && (s_waddr == s_raddr)) ? s_wdata : slot_mem[s_raddr];
            sq_idx_reg <= s_raddr;
        end
    end

    // ready order memory
    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            rdy_mem[r_waddr] <= r_wdata;
        end
        if (r_re)
        begin
            rdy_q      <= (r_we && (r_waddr == r_raddr)) ? r_wdata : rdy_mem[r_raddr];
            rq_idx_reg <= r_raddr;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        has_cur_next    = has_cur_reg;
        cur_next        = cur_reg;
        rc_next         = rc_reg;
        alloc_next      = alloc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        low_next        = low_reg;
        high_next       = high_reg;
        tpu_next        = tpu_reg;
        sk_next         = sk_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        resched_next    = resched_reg;
        recalc_next     = recalc_reg;
        found_next      = found_reg;
        best_valid_next = best_valid_reg;
        lowered_next    = lowered_reg;
        cnt_next        = cnt_reg;
        mode_next       = mode_reg;
        units_next      = units_reg;
        newp_next       = newp_reg;
        prev_has_next   = prev_has_reg;
        prev_cur_next   = prev_cur_reg;
        stat_next       = stat_reg;
        created_next    = created_reg;
        cur_eff_next    = cur_eff_reg;
        ch_base_next    = ch_base_reg;
        ch_eff_next     = ch_eff_reg;
        best_next       = best_reg;
        best_rec_next   = best_rec_reg;
        rec_next        = rec_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        o_status_next   = o_status_reg;
        o_created_next  = o_created_reg;
        o_running_next  = o_running_reg;
        o_idle_next     = o_idle_reg;
        o_switched_next = o_switched_reg;
        o_recalc_next   = o_recalc_reg;

        s_re    = 1'b0;
        s_raddr = cur_reg;
        s_we    = 1'b0;
        s_waddr = cur_reg;
        s_wdata = slot_q;
        r_re    = 1'b0;
        r_raddr = sk_reg[SW-1:0];
        r_we    = 1'b0;
        r_waddr = rc_reg[SW-1:0];
        r_wdata = sq_idx_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                epts_pkg::CFG_LOWEST:  low_next  = cfg_data;
                epts_pkg::CFG_HIGHEST: high_next = cfg_data;
                epts_pkg::CFG_TICKS:   tpu_next  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    mode_next     = mode;
                    units_next    = sleep_units;
                    newp_next     = new_priority;
                    prev_has_next = has_cur_reg;
                    prev_cur_next = cur_reg;
                    stat_next     = epts_pkg::STAT_OK;
                    created_next  = '0;
                    recalc_next   = 1'b0;
                    resched_next  = 1'b0;
                    // fetch the running task's record up front
                    s_re          = 1'b1;
                    s_raddr       = cur_reg;
                    unique case (mode)
                        epts_pkg::MODE_TICK:
                        begin
                            sk_next    = '0;
                            v1_next    = 1'b0;
                            state_next = has_cur_reg ? S_CUR : S_WAKE;
                        end
                        epts_pkg::MODE_CREATE:
                        begin
                            if (alloc_reg == CW'(SLOTS))
                            begin
                                stat_next  = epts_pkg::STAT_NO_SLOT;
                                state_next = S_DONE;
                            end
                            else if (has_cur_reg)
                            begin
                                state_next = S_CUR;
                            end
                            else
                            begin
                                ch_base_next = low_reg;
                                ch_eff_next  = EW'(low_reg);
                                state_next   = S_CHILD;
                            end
                        end
                        epts_pkg::MODE_TERM, epts_pkg::MODE_SLEEP:
                        begin
                            if (!has_cur_reg)
                            begin
                                stat_next  = epts_pkg::STAT_NO_CUR;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_CUR;
                            end
                        end
                        epts_pkg::MODE_SETP:
                        begin
                            if (!has_cur_reg)
                            begin
                                stat_next  = epts_pkg::STAT_NO_CUR;
                                state_next = S_DONE;
                            end
                            else if ((new_priority < low_reg) || (new_priority > high_reg))
                            begin
                                stat_next  = epts_pkg::STAT_BAD_PRIO;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_CUR;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            S_CUR:
            begin
                sk_next    = '0;
                v1_next    = 1'b0;
                found_next = 1'b0;
                s_waddr    = cur_reg;
                unique case (mode_reg)
                    epts_pkg::MODE_TICK:
                    begin
                        s_we          = 1'b1;
                        s_wdata.eff   = eff_dec;
                        cur_eff_next  = eff_dec;
                        if (eff_dec == '0)
                        begin
                            resched_next = 1'b1;
                        end
                        state_next = S_WAKE;
                    end
                    epts_pkg::MODE_CREATE:
                    begin
                        ch_base_next = slot_q.base;
                        if ((slot_q.base == low_reg) && (slot_q.eff <= EW'(low_reg)))
                        begin
                            ch_eff_next = slot_q.eff;
                        end
                        else
                        begin
                            // parent and child split the parent's share
                            ch_eff_next = slot_q.eff >> 1;
                            s_we        = 1'b1;
                            s_wdata.eff = slot_q.eff >> 1;
                        end
                        state_next = S_CHILD;
                    end
                    epts_pkg::MODE_TERM:
                    begin
                        s_we         = 1'b1;
                        s_wdata.st   = epts_pkg::ST_DEAD;
                        has_cur_next = 1'b0;
                        state_next   = S_REMOVE;
                    end
                    epts_pkg::MODE_SLEEP:
                    begin
                        s_we          = 1'b1;
                        s_wdata.st    = epts_pkg::ST_SLEEP;
                        s_wdata.sleep = (sleep_prod == '0) ? SLW'(1) : sleep_prod;
                        has_cur_next  = 1'b0;
                        state_next    = S_REMOVE;
                    end
                    epts_pkg::MODE_SETP:
                    begin
                        rec_next     = slot_q;
                        lowered_next = set_lower;
                        if (!set_lower && (slot_q.base == 8'd0))
                        begin
                            s_we         = 1'b1;
                            s_wdata.base = newp_reg;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            num_next   = set_prod;
                            rem_next   = '0;
                            dvs_next   = set_lower ? {1'b0, slot_q.base} : {slot_q.base, 1'b0};
                            cnt_next   = DCW'(NW);
                            state_next = S_DIV;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end

            S_CHILD:
            begin
                s_we          = 1'b1;
                s_waddr       = alloc_reg[SW-1:0];
                s_wdata.st    = epts_pkg::ST_READY;
                s_wdata.base  = ch_base_reg;
                s_wdata.eff   = ch_eff_reg;
                s_wdata.sleep = '0;
                created_next  = alloc_reg[SW-1:0];
                alloc_next    = alloc_reg + CW'(1);
                if (rc_reg < CW'(SLOTS))
                begin
                    r_we    = 1'b1;
                    r_waddr = rc_reg[SW-1:0];
                    r_wdata = alloc_reg[SW-1:0];
                    rc_next = rc_reg + CW'(1);
                end
                state_next = has_cur_reg ? S_DONE : S_SEL;
            end

            S_WAKE:
            begin
                if (sk_reg < CW'(SLOTS))
                begin
                    s_re    = 1'b1;
                    s_raddr = sk_reg[SW-1:0];
                    sk_next = sk_reg + CW'(1);
                    v1_next = 1'b1;
                end
                else
                begin
                    v1_next = 1'b0;
                end
                if (v1_reg && (sq_st == epts_pkg::ST_SLEEP))
                begin
                    s_we    = 1'b1;
                    s_waddr = sq_idx_reg;
                    if (slot_q.sleep <= SLW'(1))
                    begin
                        s_wdata.sleep = '0;
                        s_wdata.st    = epts_pkg::ST_READY;
                        if (rc_reg < CW'(SLOTS))
                        begin
                            r_we    = 1'b1;
                            r_waddr = rc_reg[SW-1:0];
                            r_wdata = sq_idx_reg;
                            rc_next = rc_reg + CW'(1);
                        end
                        if (!has_cur_reg || (slot_q.eff > cur_eff_reg))
                        begin
                            resched_next = 1'b1;
                        end
                    end
                    else
                    begin
                        s_wdata.sleep = slot_q.sleep - SLW'(1);
                    end
                end
                if ((sk_reg == CW'(SLOTS)) && !v1_reg)
                begin
                    if (resched_reg || (!has_cur_reg && (rc_reg != '0)))
                    begin
                        state_next = S_SEL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_REMOVE:
            begin
                if (sk_reg < rc_reg)
                begin
                    r_re    = 1'b1;
                    r_raddr = sk_reg[SW-1:0];
                    sk_next = sk_reg + CW'(1);
                    v1_next = 1'b1;
                end
                else
                begin
                    v1_next = 1'b0;
                end
                if (v1_reg)
                begin
                    if (found_reg)
                    begin
                        // close the gap left by the removed entry
                        r_we    = 1'b1;
                        r_waddr = rq_idx_reg - SW'(1);
                        r_wdata = rdy_q;
                    end
                    else if (rdy_q == cur_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                if ((sk_reg >= rc_reg) && !v1_reg)
                begin
                    if (found_reg)
                    begin
                        rc_next = rc_reg - CW'(1);
                    end
                    state_next = S_SEL;
                end
            end

            S_DIV:
            begin
                rem_next = div_take ? 9'(rem_sh - {1'b0, dvs_reg}) : rem_sh[8:0];
                num_next = {num_reg[NW-2:0], div_take};
                cnt_next = cnt_reg - DCW'(1);
                if (cnt_reg == DCW'(1))
                begin
                    state_next = S_PRIO_WR;
                end
            end

            S_PRIO_WR:
            begin
                s_we         = 1'b1;
                s_waddr      = cur_reg;
                s_wdata      = rec_reg;
                s_wdata.base = newp_reg;
                s_wdata.eff  = lowered_reg ? num_reg[EW-1:0] : q_sat;
                state_next   = lowered_reg ? S_SEL : S_DONE;
            end

            S_SEL:
            begin
                if (rc_reg == '0)
                begin
                    has_cur_next = 1'b0;
                    cur_next     = '0;
                    state_next   = S_DONE;
                end
                else
                begin
                    sk_next         = '0;
                    v1_next         = 1'b0;
                    v2_next         = 1'b0;
                    best_valid_next = 1'b0;
                    state_next      = S_PICK;
                end
            end

            S_PICK:
            begin
                // ready order read, then record read, then compare
                if (sk_reg < rc_reg)
                begin
                    r_re    = 1'b1;
                    r_raddr = sk_reg[SW-1:0];
                    sk_next = sk_reg + CW'(1);
                    v1_next = 1'b1;
                end
                else
                begin
                    v1_next = 1'b0;
                end
                if (v1_reg)
                begin
                    s_re    = 1'b1;
                    s_raddr = rdy_q;
                    v2_next = 1'b1;
                end
                else
                begin
                    v2_next = 1'b0;
                end
                if (v2_reg)
                begin
                    if (!best_valid_reg || (slot_q.eff > best_rec_reg.eff))
                    begin
                        best_next     = sq_idx_reg;
                        best_rec_next = slot_q;
                    end
                    best_valid_next = 1'b1;
                end
                if ((sk_reg >= rc_reg) && !v1_reg && !v2_reg)
                begin
                    state_next = S_PICK_END;
                end
            end

            S_PICK_END:
            begin
                if ((best_rec_reg.eff == '0) && !recalc_reg)
                begin
                    sk_next    = '0;
                    v1_next    = 1'b0;
                    state_next = S_RECALC;
                end
                else if (has_cur_reg)
                begin
                    s_re       = 1'b1;
                    s_raddr    = cur_reg;
                    state_next = S_DEMOTE;
                end
                else
                begin
                    state_next = S_PROMOTE;
                end
            end

            S_RECALC:
            begin
                if (sk_reg < CW'(SLOTS))
                begin
                    s_re    = 1'b1;
                    s_raddr = sk_reg[SW-1:0];
                    sk_next = sk_reg + CW'(1);
                    v1_next = 1'b1;
                end
                else
                begin
                    v1_next = 1'b0;
                end
                if (v1_reg && ((sq_st == epts_pkg::ST_READY) || (sq_st == epts_pkg::ST_RUN) ||
                               (sq_st == epts_pkg::ST_SLEEP)))
                begin
                    s_we        = 1'b1;
                    s_waddr     = sq_idx_reg;
                    s_wdata.eff = recalc_eff;
                end
                if ((sk_reg == CW'(SLOTS)) && !v1_reg)
                begin
                    recalc_next = 1'b1;
                    state_next  = S_SEL;
                end
            end

            S_DEMOTE:
            begin
                if (sq_st == epts_pkg::ST_RUN)
                begin
                    s_we       = 1'b1;
                    s_waddr    = cur_reg;
                    s_wdata.st = epts_pkg::ST_READY;
                end
                state_next = S_PROMOTE;
            end

            S_PROMOTE:
            begin
                s_we         = 1'b1;
                s_waddr      = best_reg;
                s_wdata      = best_rec_reg;
                s_wdata.st   = epts_pkg::ST_RUN;
                cur_next     = best_reg;
                has_cur_next = 1'b1;
                state_next   = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    o_status_next   = stat_reg;
                    o_created_next  = created_ext[3:0];
                    o_running_next  = has_cur_reg ? cur_ext[3:0] : 4'd0;
                    o_idle_next     = !has_cur_reg;
                    o_switched_next = (prev_has_reg != has_cur_reg) ||
                                      (has_cur_reg && (prev_cur_reg != cur_reg));
                    o_recalc_next   = recalc_reg;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            has_cur_reg    <= 1'b0;
            cur_reg        <= '0;
            rc_reg         <= '0;
            alloc_reg      <= '0;
            out_valid_reg  <= 1'b0;
            low_reg        <= epts_pkg::LOWEST_RST;
            high_reg       <= epts_pkg::HIGHEST_RST;
            tpu_reg        <= epts_pkg::TICKS_RST;
            sk_reg         <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            resched_reg    <= 1'b0;
            recalc_reg     <= 1'b0;
            found_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
            lowered_reg    <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            has_cur_reg    <= has_cur_next;
            cur_reg        <= cur_next;
            rc_reg         <= rc_next;
            alloc_reg      <= alloc_next;
            out_valid_reg  <= out_valid_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            tpu_reg        <= tpu_next;
            sk_reg         <= sk_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            resched_reg    <= resched_next;
            recalc_reg     <= recalc_next;
            found_reg      <= found_next;
            best_valid_reg <= best_valid_next;
            lowered_reg    <= lowered_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        units_reg      <= units_next;
        newp_reg       <= newp_next;
        prev_has_reg   <= prev_has_next;
        prev_cur_reg   <= prev_cur_next;
        stat_reg       <= stat_next;
        created_reg    <= created_next;
        cur_eff_reg    <= cur_eff_next;
        ch_base_reg    <= ch_base_next;
        ch_eff_reg     <= ch_eff_next;
        best_reg       <= best_next;
        best_rec_reg   <= best_rec_next;
        rec_reg        <= rec_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        o_status_reg   <= o_status_next;
        o_created_reg  <= o_created_next;
        o_running_reg  <= o_running_next;
        o_idle_reg     <= o_idle_next;
        o_switched_reg <= o_switched_next;
        o_recalc_reg   <= o_recalc_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = o_status_reg;
    assign created_slot = o_created_reg;
    assign running_slot = o_running_reg;
    assign idle         = o_idle_reg;
    assign switched     = o_switched_reg;
    assign recalculated = o_recalc_reg;

`ifndef SYNTHESIS
    a_rc_le_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg <= alloc_reg)
        else $error("ready order longer than allocated slots");

    a_cur_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        has_cur_reg |-> (CW'(cur_reg) < alloc_reg))
        else $error("running slot never allocated");

    a_recalc_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && recalculated) |-> !idle)
        else $error("recalculation reported with no task running");
`endif

endmodule

`default_nettype wire
